// File: src/bdeq_pkg.sv
package bdeq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int WORD_W     = 32;
  localparam int CAP_W      = 5;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_RESET  = 16;

  typedef logic [DATA_WIDTH-1:0] entry_t;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cell control for one update
  typedef struct packed {
    logic load;       // take the pushed item
    logic from_left;  // take the neighbor toward the front
    logic from_right; // take the neighbor toward the rear
    logic tap_cur;    // drive current contents onto the pop tap chain
    logic tap_next;   // drive updated contents onto the tail tap chain
  } cell_ctl_t;

endpackage

// File: src/bdeq_cell.sv
module bdeq_cell (
  input  logic                clk,
  input  bdeq_pkg::cell_ctl_t ctl,
  input  bdeq_pkg::entry_t    load_data,
  input  bdeq_pkg::entry_t    left_data,
  input  bdeq_pkg::entry_t    right_data,
  input  bdeq_pkg::entry_t    cur_tap_in,
  input  bdeq_pkg::entry_t    next_tap_in,
  output bdeq_pkg::entry_t    data,
  output bdeq_pkg::entry_t    cur_tap_out,
  output bdeq_pkg::entry_t    next_tap_out
);
  import bdeq_pkg::*;

  entry_t data_next;

  always_comb begin
    if (ctl.load) begin
      data_next = load_data;
    end else if (ctl.from_left) begin
      data_next = left_data;
    end else if (ctl.from_right) begin
      data_next = right_data;
    end else begin
      data_next = data;
    end
  end

  // taps are or-ed along the row; at most one cell drives each chain
  assign cur_tap_out  = cur_tap_in  | (ctl.tap_cur  ? data      : '0);
  assign next_tap_out = next_tap_in | (ctl.tap_next ? data_next : '0);

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// File: src/bounded_double_ended_queue.sv
// Fixed-capacity double-ended queue of signed words, built as a row of DEPTH
// cells. Cell 0 is the head; entry k sits in cell k. Push front shifts the
// whole row one cell toward the rear and loads cell 0; pop front shifts it one
// cell toward the head; push rear and pop rear touch only the tail cell. Every
// accepted item yields exactly one result, registered on the edge that accepts
// it, carrying the status and the head, tail and count as they stand after
// the action. A new item is accepted in every cycle in which the result
// register is empty or being drained, so the sustained rate is one item per
// clock, set by the single result register and the registered row update.
// A push on a full queue or a pop on an empty one changes nothing and
// reports a reject status. The user writes capacity (cfg channel) only while
// the queue is idle; the block does not enforce this. It reads 0 as 1, values
// above DEPTH as DEPTH; lowering it below the count keeps the stored entries.
module bounded_double_ended_queue (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: capacity
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bdeq_pkg::CAP_W-1:0]  cfg_data,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic signed [31:0]          push_value,
  // result items
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic signed [31:0]          popped_value,
  output logic signed [31:0]          front_value,
  output logic signed [31:0]          rear_value,
  output logic [4:0]                  occupancy,
  output logic                        is_empty,
  output logic                        is_full
);
  import bdeq_pkg::*;

  // control state
  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] cap_eff;

  // cell row
  cell_ctl_t ctl [DEPTH];
  entry_t    cell_data [DEPTH];
  entry_t    cur_tap [DEPTH+1];
  entry_t    next_tap [DEPTH+1];
  entry_t    push_entry;

  logic    accept;
  logic    is_push;
  logic    full_now;
  logic    empty_now;
  logic    push_ok;
  logic    pop_ok;
  action_t act;
  status_t status_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign act       = action_t'(action);

  // the pushed word is kept at the stored width
  assign push_entry = DATA_WIDTH'(push_value);

  // 0 counts as 1, anything above the built depth as the depth
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(capacity) > DEPTH) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign is_push   = (act == ACT_PUSH_FRONT) || (act == ACT_PUSH_REAR);
  assign full_now  = (count >= cap_eff);
  assign empty_now = (count == '0);
  assign push_ok   = accept && is_push && !full_now;
  assign pop_ok    = accept && !is_push && !empty_now;

  always_comb begin
    if (push_ok) begin
      count_next = count + CNT_W'(1);
    end else if (pop_ok) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  always_comb begin
    if (accept && is_push && full_now) begin
      status_next = ST_FULL;
    end else if (accept && !is_push && empty_now) begin
      status_next = ST_EMPTY;
    end else begin
      status_next = ST_DONE;
    end
  end

  // Per-cell controls. Each cell compares the count against its own place:
  // the tail is the cell whose place plus one equals the count.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].load       = 1'b0;
      ctl[i].from_left  = 1'b0;
      ctl[i].from_right = 1'b0;
      ctl[i].tap_cur    = 1'b0;
      ctl[i].tap_next   = (count_next == CNT_W'(i + 1));
      case (act)
        ACT_PUSH_FRONT: begin
          ctl[i].load      = push_ok && (i == 0);
          ctl[i].from_left = push_ok && (i != 0);
        end
        ACT_PUSH_REAR: begin
          ctl[i].load = push_ok && (count == CNT_W'(i));
        end
        ACT_POP_FRONT: begin
          ctl[i].from_right = pop_ok && (i != DEPTH - 1);
          ctl[i].tap_cur    = pop_ok && (i == 0);
        end
        ACT_POP_REAR: begin
          ctl[i].tap_cur = pop_ok && (count == CNT_W'(i + 1));
        end
        default: begin
          ctl[i].load = 1'b0;
        end
      endcase
    end
  end

  assign cur_tap[0]  = '0;
  assign next_tap[0] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t left_in;
    entry_t right_in;

    if (g == 0) begin : g_head
      assign left_in = push_entry;
    end else begin : g_mid
      assign left_in = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_in = cell_data[g];
    end else begin : g_body
      assign right_in = cell_data[g+1];
    end

    bdeq_cell u_cell (
      .clk          (clk),
      .ctl          (ctl[g]),
      .load_data    (push_entry),
      .left_data    (left_in),
      .right_data   (right_in),
      .cur_tap_in   (cur_tap[g]),
      .next_tap_in  (next_tap[g]),
      .data         (cell_data[g]),
      .cur_tap_out  (cur_tap[g+1]),
      .next_tap_out (next_tap[g+1])
    );
  end

  // head after the action, taken from the update in flight; a push at either
  // end of an empty queue puts the new word at the head
  entry_t head_next;
  always_comb begin
    if (count_next == '0) begin
      head_next = '0;
    end else if (push_ok && ((act == ACT_PUSH_FRONT) || empty_now)) begin
      head_next = push_entry;
    end else if (pop_ok && (act == ACT_POP_FRONT)) begin
      head_next = (DEPTH > 1) ? cell_data[(DEPTH > 1) ? 1 : 0] : '0;
    end else begin
      head_next = cell_data[0];
    end
  end

  // configuration and count
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(CAP_RESET);
      count    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // stored words are sign-extended from the stored width to the 32-bit fields
  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      popped_value <= WORD_W'(signed'(cur_tap[DEPTH]));
      front_value  <= WORD_W'(signed'(head_next));
      rear_value   <= WORD_W'(signed'(next_tap[DEPTH]));
      occupancy    <= 5'(count_next);
      is_empty     <= (count_next == '0);
      is_full      <= (count_next >= cap_eff);
    end
  end

endmodule
